FILE: rtl/hgm_pkg.sv
package hgm_pkg;

  localparam int SAMPLE_W       = 16;  // height sample
  localparam int DIM_W          = 11;  // frame_width / frame_height registers
  localparam int SCALE_W        = 16;  // grad_scale, Q0.16
  localparam int IDX_W          = 10;  // col_index / row_index
  localparam int MAG_W          = 25;  // grad_magnitude, 8 fractional bits
  localparam int DIFF_W         = 17;  // central difference of two samples
  localparam int ABS_W          = 16;  // |difference|
  localparam int SLOPE_W        = 24;  // |d| * scale >> 8
  localparam int SUM_W          = 50;  // dx^2 + dy^2, even for the root
  localparam int FRAC_DROP      = 8;
  localparam int CFG_INDEX_W    = 2;
  localparam int CFG_DATA_W     = 16;
  localparam int QUEUE_DEPTH    = 4;
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int DEF_DIM        = 1024;
  localparam int DEF_GRAD_SCALE = 4096;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_GRAD_SCALE   = 2'd2
  } cfg_reg_t;

  // one pixel's work for the back end
  typedef struct packed {
    logic [IDX_W-1:0]         col;
    logic [IDX_W-1:0]         row;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic                     last;
  } hgm_job_t;

endpackage

FILE: rtl/hgm_in_if.sv
interface hgm_in_if;
  import hgm_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] height_sample;

  modport source (output valid, output height_sample, input ready);
  modport sink   (input valid, input height_sample, output ready);
endinterface

FILE: rtl/hgm_out_if.sv
interface hgm_out_if;
  import hgm_pkg::*;

  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] col_index;
  logic [IDX_W-1:0] row_index;
  logic [MAG_W-1:0] grad_magnitude;
  logic             frame_end;

  modport source (output valid, output col_index, output row_index,
                  output grad_magnitude, output frame_end, input ready);
  modport sink   (input valid, input col_index, input row_index,
                  input grad_magnitude, input frame_end, output ready);
endinterface

FILE: rtl/hgm_front.sv
module hgm_front #(
  parameter int MAX_WIDTH  = hgm_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = hgm_pkg::DEF_MAX_HEIGHT
) (
  input  logic                      clk,
  input  logic                      rst,
  hgm_in_if.sink                    samples,
  input  logic [hgm_pkg::DIM_W-1:0] frame_width,
  input  logic [hgm_pkg::DIM_W-1:0] frame_height,
  input  logic                      restart,
  output logic                      q_push,
  output hgm_pkg::hgm_job_t         q_job,
  input  logic                      q_full
);
  import hgm_pkg::*;

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_READ = 3'b010,
    F_EMIT = 3'b100
  } front_state_t;

  front_state_t state;

  logic signed [SAMPLE_W-1:0] older_mem [MAX_WIDTH];
  logic signed [SAMPLE_W-1:0] newer_mem [MAX_WIDTH];

  logic [AW-1:0] col;
  logic [RW-1:0] row;
  logic signed [SAMPLE_W-1:0] sample, prev1, prev2, above_prev;
  logic signed [SAMPLE_W-1:0] rd_cur, rd_right, rd_old;
  hgm_job_t jobs [3];
  logic [2:0] pend;

  logic          last_col, last_row, accept;
  logic [AW-1:0] right_addr;
  logic signed [SAMPLE_W-1:0] l0, r0, u0, d0, l1, u1, l2, u2;
  hgm_job_t j0, j1, j2;

  assign samples.ready = (state == F_IDLE);
  assign accept   = samples.valid && samples.ready;
  assign last_col = (32'(col) + 32'd1 == 32'(frame_width));
  assign last_row = (32'(row) + 32'd1 == 32'(frame_height));
  assign right_addr = last_col ? col : col + AW'(1);

  // line stores: read on accept, written back in the cycle after
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_cur   <= newer_mem[col];
      rd_right <= newer_mem[right_addr];
      rd_old   <= older_mem[col];
    end
    if (state == F_READ) begin
      older_mem[col] <= rd_cur;
      newer_mem[col] <= sample;
    end
  end

  // pixel one row up
  always_comb begin
    l0 = (col != '0) ? above_prev : rd_cur;
    r0 = rd_right;
    u0 = (32'(row) >= 32'd2) ? rd_old : rd_cur;
    d0 = sample;
    j0.col  = IDX_W'(col);
    j0.row  = IDX_W'(row - RW'(1));
    j0.dx   = DIFF_W'(r0) - DIFF_W'(l0);
    j0.dy   = DIFF_W'(d0) - DIFF_W'(u0);
    j0.last = 1'b0;
  end

  // last row: left neighbour of the current pixel
  always_comb begin
    l1 = (32'(col) >= 32'd2) ? prev2 : prev1;
    u1 = (row != '0) ? above_prev : prev1;
    j1.col  = IDX_W'(col - AW'(1));
    j1.row  = IDX_W'(row);
    j1.dx   = DIFF_W'(sample) - DIFF_W'(l1);
    j1.dy   = DIFF_W'(prev1) - DIFF_W'(u1);
    j1.last = 1'b0;
  end

  // last row, last column: frame flush
  always_comb begin
    l2 = (col != '0) ? prev1 : sample;
    u2 = (row != '0) ? rd_cur : sample;
    j2.col  = IDX_W'(col);
    j2.row  = IDX_W'(row);
    j2.dx   = DIFF_W'(sample) - DIFF_W'(l2);
    j2.dy   = DIFF_W'(sample) - DIFF_W'(u2);
    j2.last = 1'b1;
  end

  always_comb begin
    q_push = (state == F_EMIT) && !q_full;
    if (pend[0]) begin
      q_job = jobs[0];
    end else if (pend[1]) begin
      q_job = jobs[1];
    end else begin
      q_job = jobs[2];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample <= samples.height_sample;
    end
    if (state == F_READ) begin
      jobs[0]    <= j0;
      jobs[1]    <= j1;
      jobs[2]    <= j2;
      above_prev <= rd_cur;
      prev2      <= prev1;
      prev1      <= sample;
    end
    if (rst) begin
      state      <= F_IDLE;
      col        <= '0;
      row        <= '0;
      pend       <= '0;
      above_prev <= '0;
    end else begin
      case (state)
        F_IDLE: begin
          if (accept) begin
            state <= F_READ;
          end
        end
        F_READ: begin
          pend[0] <= (row != '0);
          pend[1] <= last_row && (col != '0);
          pend[2] <= last_row && last_col;
          if ((row != '0) || (last_row && ((col != '0) || last_col))) begin
            state <= F_EMIT;
          end else begin
            state <= F_IDLE;
          end
          if (!last_col) begin
            col <= col + AW'(1);
          end else begin
            col <= '0;
            row <= last_row ? '0 : row + RW'(1);
          end
        end
        F_EMIT: begin
          if (!q_full) begin
            if (pend[0]) begin
              pend[0] <= 1'b0;
              if (pend[2:1] == 2'b00) state <= F_IDLE;
            end else if (pend[1]) begin
              pend[1] <= 1'b0;
              if (!pend[2]) state <= F_IDLE;
            end else begin
              pend[2] <= 1'b0;
              state   <= F_IDLE;
            end
          end
        end
        default: state <= F_IDLE;
      endcase
      if (restart) begin
        col <= '0;
        row <= '0;
      end
    end
  end

endmodule

FILE: rtl/hgm_job_queue.sv
module hgm_job_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  hgm_pkg::hgm_job_t push_job,
  output logic              full,
  input  logic              pop,
  output hgm_pkg::hgm_job_t pop_job,
  output logic              empty
);
  import hgm_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  hgm_job_t       slots [QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr, rd_ptr;
  logic [PW:0]    count;

  assign full    = (count == (PW+1)'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign pop_job = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_job;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) wr_ptr <= wr_ptr + PW'(1);
      if (pop && !empty) rd_ptr <= rd_ptr + PW'(1);
      count <= count + (PW+1)'(push && !full) - (PW+1)'(pop && !empty);
    end
  end

endmodule

FILE: rtl/hgm_back.sv
module hgm_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [hgm_pkg::SCALE_W-1:0] grad_scale,
  output logic                        q_pop,
  input  hgm_pkg::hgm_job_t           q_job,
  input  logic                        q_empty,
  hgm_out_if.source                   grads
);
  import hgm_pkg::*;

  typedef enum logic [6:0] {
    B_IDLE = 7'b0000001,
    B_MULX = 7'b0000010,
    B_MULY = 7'b0000100,
    B_SQX  = 7'b0001000,
    B_SQY  = 7'b0010000,
    B_ROOT = 7'b0100000,
    B_OUT  = 7'b1000000
  } back_state_t;

  back_state_t state;

  logic [IDX_W-1:0]   col, row;
  logic               last;
  logic [ABS_W-1:0]   ax, ay, mul_a;
  logic [SLOPE_W-1:0] sx, sy, sq_a;
  logic [ABS_W+SCALE_W-1:0] prod;
  logic [SUM_W-1:0]   sq, acc, res, bitv, trial;
  logic               out_free;

  function automatic logic [ABS_W-1:0] abs_diff(input logic signed [DIFF_W-1:0] d);
    logic signed [DIFF_W-1:0] n;
    n = -d;
    return d[DIFF_W-1] ? n[ABS_W-1:0] : d[ABS_W-1:0];
  endfunction

  assign q_pop    = (state == B_IDLE) && !q_empty;
  assign out_free = !grads.valid || grads.ready;

  // one shared scale multiplier, one shared squarer
  assign mul_a = (state == B_MULX) ? ax : ay;
  assign prod  = (ABS_W+SCALE_W)'(mul_a) * (ABS_W+SCALE_W)'(grad_scale);
  assign sq_a  = (state == B_SQX) ? sx : sy;
  assign sq    = SUM_W'(sq_a) * SUM_W'(sq_a);
  assign trial = res + bitv;

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        col  <= q_job.col;
        row  <= q_job.row;
        last <= q_job.last;
        ax   <= abs_diff(q_job.dx);
        ay   <= abs_diff(q_job.dy);
      end
      B_MULX: sx <= prod[FRAC_DROP +: SLOPE_W];
      B_MULY: sy <= prod[FRAC_DROP +: SLOPE_W];
      B_SQX:  acc <= sq;
      B_SQY: begin
        acc  <= acc + sq;
        res  <= '0;
        bitv <= SUM_W'(1) << (SUM_W - 2);
      end
      B_ROOT: begin
        // restoring square root, one result bit a cycle
        if (acc >= trial) begin
          acc <= acc - trial;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
      end
      default: ;
    endcase
    if (state == B_OUT && out_free) begin
      grads.col_index      <= col;
      grads.row_index      <= row;
      grads.grad_magnitude <= res[MAG_W-1:0];
      grads.frame_end      <= last;
    end
    if (rst) begin
      state       <= B_IDLE;
      grads.valid <= 1'b0;
    end else begin
      if (state == B_OUT && out_free) begin
        grads.valid <= 1'b1;
      end else if (grads.ready) begin
        grads.valid <= 1'b0;
      end
      case (state)
        B_IDLE: if (!q_empty) state <= B_MULX;
        B_MULX: state <= B_MULY;
        B_MULY: state <= B_SQX;
        B_SQX:  state <= B_SQY;
        B_SQY:  state <= B_ROOT;
        B_ROOT: if (bitv[0]) state <= B_OUT;
        B_OUT:  if (out_free) state <= B_IDLE;
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/heightmap_gradient_magnitude.sv
// Height-map gradient magnitude, central differences, streamed in raster order.
// samples: one signed 16-bit height word per handshake (valid/ready), row by row.
// grads:   one word per output pixel: column, row, magnitude (8 fraction bits)
//          and frame_end on the last pixel of the frame.
// cfg:     cfg_we/cfg_index/cfg_data write frame_width, frame_height, grad_scale;
//          a dimension write restarts the frame at pixel (0,0). Write only when idle.
// Pixel (x,y) leaves once sample (x,y+1) is in; the last row is emitted as it
// arrives, the final sample flushing the corner pixel.
// Flow: the front end takes a new sample only after it has queued each pixel
// (0 to 3) that the last one produced. Each output pixel passes through the back
// end in turn: pop, scale multiply x2, square x2, the bit-serial square root and
// the output load; the back end takes no new pixel before that, which sets the
// sustained rate in mid-frame.
// A 4-deep job queue sits between front and back; a stalled receiver holds the
// output register, the back end then stops, the queue fills and samples.ready drops.
// Reset clears counters, control and config (1024 x 1024, scale 4096); line
// stores are not cleared and need no clearing pass.
module heightmap_gradient_magnitude #(
  parameter int MAX_WIDTH  = hgm_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = hgm_pkg::DEF_MAX_HEIGHT
) (
  input  logic                            clk,
  input  logic                            rst,
  hgm_in_if.sink                          samples,
  hgm_out_if.source                       grads,
  input  logic                            cfg_we,
  input  logic [hgm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [hgm_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import hgm_pkg::*;

  // reset dims are clamped to the build maxima
  localparam logic [DIM_W-1:0] WIDTH_RST  =
    DIM_W'((MAX_WIDTH < DEF_DIM) ? MAX_WIDTH : DEF_DIM);
  localparam logic [DIM_W-1:0] HEIGHT_RST =
    DIM_W'((MAX_HEIGHT < DEF_DIM) ? MAX_HEIGHT : DEF_DIM);

  logic [DIM_W-1:0]   frame_width, frame_height;
  logic [SCALE_W-1:0] grad_scale;
  logic [DIM_W-1:0]   dim_in, width_next, height_next;
  logic               restart;

  logic     q_push, q_full, q_pop, q_empty;
  hgm_job_t push_job, pop_job;

  // only the low 11 bits count: zero reads as one, anything above the maximum as the maximum
  assign dim_in = cfg_data[DIM_W-1:0];
  always_comb begin
    if (dim_in == '0) begin
      width_next  = DIM_W'(1);
      height_next = DIM_W'(1);
    end else begin
      width_next  = (32'(dim_in) > MAX_WIDTH)  ? DIM_W'(MAX_WIDTH)  : dim_in;
      height_next = (32'(dim_in) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : dim_in;
    end
  end

  assign restart = cfg_we && ((cfg_index == REG_FRAME_WIDTH) ||
                              (cfg_index == REG_FRAME_HEIGHT));

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_RST;
      frame_height <= HEIGHT_RST;
      grad_scale   <= SCALE_W'(DEF_GRAD_SCALE);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= width_next;
        REG_FRAME_HEIGHT: frame_height <= height_next;
        REG_GRAD_SCALE:   grad_scale   <= cfg_data[SCALE_W-1:0];
        default: ;  // unused index
      endcase
    end
  end

  // front: line stores, window, job generation
  hgm_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .samples     (samples),
    .frame_width (frame_width),
    .frame_height(frame_height),
    .restart     (restart),
    .q_push      (q_push),
    .q_job       (push_job),
    .q_full      (q_full)
  );

  hgm_job_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .push_job(push_job),
    .full    (q_full),
    .pop     (q_pop),
    .pop_job (pop_job),
    .empty   (q_empty)
  );

  // back: scaling, squares, root, output register
  hgm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .grad_scale(grad_scale),
    .q_pop     (q_pop),
    .q_job     (pop_job),
    .q_empty   (q_empty),
    .grads     (grads)
  );

endmodule

FILE: tb/sv/tb_heightmap_gradient_magnitude.sv
`timescale 1ns / 1ps

module tb_heightmap_gradient_magnitude;
  import hgm_pkg::*;

  // one gradient word as the block should present it
  typedef struct {
    logic [IDX_W-1:0] col;
    logic [IDX_W-1:0] row;
    logic [MAG_W-1:0] mag;
    logic             last;
  } grad_word_t;

  localparam int LINE_LEN   = DEF_MAX_WIDTH;
  localparam int SETTLE_CYC = 40;    // settle time at the end of drain, cycles
  localparam int LONG_HOLD  = 400;   // receiver hold-off, cycles

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_FRAME_WIDTH;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  hgm_in_if  in_if ();
  hgm_out_if out_if ();

  heightmap_gradient_magnitude u_dut (
    .clk      (clk),
    .rst      (rst),
    .samples  (in_if),
    .grads    (out_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #2 clk = ~clk;

  initial begin
    in_if.valid         = 1'b0;
    in_if.height_sample = '0;
    out_if.ready        = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Gradient predictor: own copy of geometry, scale, line stores and counters.
  // ---------------------------------------------------------------------------
  int unsigned frame_w, frame_h, slope_scale;
  logic signed [SAMPLE_W-1:0] line_old [LINE_LEN];
  logic signed [SAMPLE_W-1:0] line_new [LINE_LEN];
  logic signed [SAMPLE_W-1:0] displaced_above;  // above-row value of previous column
  int unsigned col_pos, row_pos;

  grad_word_t pending_grads[$];     // expected words, oldest first
  logic signed [SAMPLE_W-1:0] height_queue[$];  // samples waiting for the driver
  int errors = 0;

  function automatic int unsigned clamp_dim(int unsigned v);
    v = v & 32'h7FF;
    if (v < 1) return 1;
    if (v > LINE_LEN) return LINE_LEN;
    return v;
  endfunction

  function automatic longint unsigned scaled_slope(int d);
    longint unsigned a;
    a = (d < 0) ? longint'(-d) : longint'(d);
    return (a * slope_scale) >> FRAC_DROP;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic void queue_grad(int unsigned col, int unsigned row, int left, int right,
                                     int up, int down, bit last);
    longint unsigned sx, sy;
    grad_word_t g;
    sx = scaled_slope(right - left);
    sy = scaled_slope(down - up);
    g.col  = col[IDX_W-1:0];
    g.row  = row[IDX_W-1:0];
    g.mag  = MAG_W'(int_sqrt(sx * sx + sy * sy));
    g.last = last;
    pending_grads.push_back(g);
  endfunction

  function automatic void predict_sample(logic signed [SAMPLE_W-1:0] s);
    int unsigned x, r, xr, c;
    int left, up;
    x = col_pos;
    r = row_pos;
    if (x >= frame_w) x = frame_w - 1;
    if (r >= frame_h) r = frame_h - 1;

    // pixel of the row above, now that the one below it is known
    if (r >= 1) begin
      xr   = (x + 1 < frame_w) ? x + 1 : frame_w - 1;
      left = (x > 0) ? int'(displaced_above) : int'(line_new[0]);
      up   = (r >= 2) ? int'(line_old[x]) : int'(line_new[x]);
      queue_grad(x, r - 1, left, int'(line_new[xr]), up, int'(s), 1'b0);
    end

    displaced_above = line_new[x];
    line_old[x]     = line_new[x];
    line_new[x]     = s;

    // last row: bottom clamps to the pixel itself
    if (r == frame_h - 1) begin
      if (x >= 1) begin
        c    = x - 1;
        left = line_new[(x >= 2) ? x - 2 : 0];
        up   = (r >= 1) ? int'(line_old[c]) : int'(line_new[c]);
        queue_grad(c, r, left, int'(line_new[x]), up, int'(line_new[c]), 1'b0);
      end
      if (x == frame_w - 1) begin
        left = line_new[(x >= 1) ? x - 1 : 0];
        up   = (r >= 1) ? int'(line_old[x]) : int'(line_new[x]);
        queue_grad(x, r, left, int'(line_new[x]), up, int'(line_new[x]), 1'b1);
      end
    end

    if (x + 1 < frame_w) begin
      col_pos = x + 1;
      row_pos = r;
    end else begin
      col_pos = 0;
      row_pos = (r + 1 < frame_h) ? r + 1 : 0;
    end
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("MISMATCH %s: got %0d want %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: sends the sample queue to the block, random gaps between words when enabled.
  // ---------------------------------------------------------------------------
  bit send_gaps = 1'b1;
  bit recv_stalls = 1'b1;
  int send_gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_if.valid   <= 1'b0;
      send_gap_left = 0;
    end else begin
      // predict at the edge the word is taken
      if (in_if.valid && in_if.ready) predict_sample(in_if.height_sample);
      if (!(in_if.valid && !in_if.ready)) begin
        if (send_gap_left > 0) begin
          send_gap_left--;
          in_if.valid <= 1'b0;
        end else if (height_queue.size() > 0) begin
          in_if.height_sample <= height_queue.pop_front();
          in_if.valid         <= 1'b1;
          send_gap_left = send_gaps ? $urandom_range(0, 7) : 0;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each word taken against the predictor, random stalls on ready, plus one long hold-off on request.
  // ---------------------------------------------------------------------------
  bit hold_request = 1'b0;
  int stall_left = 0;
  int hold_left = 0;
  grad_word_t want;

  always @(posedge clk) begin
    if (rst) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (pending_grads.size() == 0) begin
          report_mismatch("unexpected word, col_index", out_if.col_index, 0);
        end else begin
          want = pending_grads.pop_front();
          if (out_if.col_index !== want.col)
            report_mismatch("col_index", out_if.col_index, want.col);
          if (out_if.row_index !== want.row)
            report_mismatch("row_index", out_if.row_index, want.row);
          if (out_if.grad_magnitude !== want.mag)
            report_mismatch("grad_magnitude", out_if.grad_magnitude, want.mag);
          if (out_if.frame_end !== want.last)
            report_mismatch("frame_end", out_if.frame_end, want.last);
        end
        stall_left = recv_stalls ? $urandom_range(0, 7) : 0;
      end
      if (hold_request) begin
        hold_left    = LONG_HOLD;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_FRAME_WIDTH: begin
        frame_w = clamp_dim(val);
        col_pos = 0;
        row_pos = 0;
      end
      REG_FRAME_HEIGHT: begin
        frame_h = clamp_dim(val);
        col_pos = 0;
        row_pos = 0;
      end
      default: slope_scale = val;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // all words sent and answered, then let the back end settle
  task automatic drain();
    while (height_queue.size() > 0 || in_if.valid) @(posedge clk);
    while (pending_grads.size() > 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic setup(int unsigned w, int unsigned h, int unsigned sc);
    write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(w));
    write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(h));
    write_reg(REG_GRAD_SCALE, CFG_DATA_W'(sc));
  endtask

  task automatic push_random(int n);
    repeat (n) height_queue.push_back(SAMPLE_W'($urandom()));
  endtask

  initial begin
    int sent, w, h, frames, n;
    bit held;
    frame_w     = DEF_DIM;
    frame_h     = DEF_DIM;
    slope_scale = DEF_GRAD_SCALE;
    col_pos     = 0;
    row_pos     = 0;
    held        = 1'b0;
    displaced_above = '0;
    for (int i = 0; i < LINE_LEN; i++) begin
      line_old[i] = '0;
      line_new[i] = '0;
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: 3x3 at full scale, field extremes so the slopes hit their peaks
    setup(3, 3, 16'hFFFF);
    height_queue.push_back(16'sh7FFF); height_queue.push_back(-16'sh8000);
    height_queue.push_back(16'sh7FFF); height_queue.push_back(-16'sh8000);
    height_queue.push_back(16'sh0000); height_queue.push_back(16'sh7FFF);
    height_queue.push_back(16'sh7FFF); height_queue.push_back(-16'sh8000);
    height_queue.push_back(-16'sh1);
    drain();
    // single pixel frames, width and height of zero read as one; zero scale
    setup(0, 0, 0);
    height_queue.push_back(16'sh7FFF); height_queue.push_back(-16'sh8000);
    drain();
    // single row, then single column
    setup(5, 1, 16'h8000);
    push_random(5);
    drain();
    setup(1, 4, 16'h1234);
    push_random(4);
    drain();

    // random frames, mostly small and complete; some cut short
    sent = 20;
    while (sent < 430) begin
      w = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 8) : $urandom_range(9, 40);
      h = $urandom_range(1, 6);
      if ($urandom_range(0, 15) == 0) w = 0;
      send_gaps   = ($urandom_range(0, 3) != 0);
      recv_stalls = ($urandom_range(0, 3) != 0);
      setup(w, h, ($urandom_range(0, 7) == 0) ? 16'hFFFF : $urandom_range(0, 65535));
      frames = $urandom_range(1, 2);
      n = clamp_dim(w) * h * frames;
      if ($urandom_range(0, 4) == 0) n = $urandom_range(1, n);
      // once, with the sender flat out, stall the receiver long enough to back up
      if (!held && sent > 150) begin
        if (n < 40) n = 40;
        held         = 1'b1;
        send_gaps    = 1'b0;
        hold_request = 1'b1;
      end
      push_random(n);
      sent += n;
      drain();
    end

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog
  initial begin
    #8ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: files.f
rtl/hgm_pkg.sv
rtl/hgm_in_if.sv
rtl/hgm_out_if.sv
rtl/hgm_front.sv
rtl/hgm_job_queue.sv
rtl/hgm_back.sv
rtl/heightmap_gradient_magnitude.sv
tb/sv/tb_heightmap_gradient_magnitude.sv
